>>> rtl/rdf_pkg.sv
`timescale 1ns / 1ps
package rdf_pkg;

   localparam int HALF_MAX    = 4;
   localparam int VALUE_WIDTH = 24;
   localparam int WIN_DEPTH   = 2 * HALF_MAX + 1;
   localparam int HALF_W      = 3;                  // width of the half width register
   localparam int SEEN_W      = 4;                  // holds 0..WIN_DEPTH
   localparam int K_W         = 4;                  // tap index 0..WIN_DEPTH-1
   localparam int NUM_WIDTH   = VALUE_WIDTH + 5;    // weighted sum, |coef| sum <= 20
   localparam int DEN_W       = 6;                  // 2*sum(n^2) <= 60
   localparam int CNT_W       = 5;                  // holds NUM_WIDTH + 1

   typedef struct packed {
      logic              load;        // take req item into the window
      logic              fill;        // first frame of a track: fill every tap
      logic              hold_shift;  // flush: shift the held last value in again
      logic              sum_en;      // rotate window and accumulate one tap
      logic [K_W-1:0]    k;           // tap being accumulated
      logic [HALF_W-1:0] h;           // effective half width
      logic              div_load;
      logic              div_step;
      logic              finish;      // saturate, fill output register
   } rdf_cmd_type;

   // 2*sum(n^2); half width 0 uses 2 so that a zero sum divides to zero
   function automatic logic [DEN_W-1:0] den_of(input logic [HALF_W-1:0] h);
      logic [DEN_W-1:0] d;
      unique case (h)
         3'd1:    d = 6'd2;
         3'd2:    d = 6'd10;
         3'd3:    d = 6'd28;
         3'd4:    d = 6'd60;
         default: d = 6'd2;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/rdf_ctrl.sv
`timescale 1ns / 1ps
module rdf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_wr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic                        rsp_tlast,
   output rdf_pkg::rdf_cmd_type        cmd
);
   import rdf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_SUM,
      S_DIV,
      S_OUT
   } state_type;

   state_type           state_ff;
   logic [HALF_W-1:0]   half_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic                last_ff;
   logic [HALF_W-1:0]   step_ff;
   logic [HALF_W-1:0]   pend_ff;
   logic                final_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic [HALF_W-1:0]   h;
   logic                accept;
   logic [SEEN_W-1:0]   seen_in;
   logic [HALF_W-1:0]   pend_in;

   assign h = (half_ff > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : half_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = final_ff;

   always_comb begin
      if (seen_ff == '0) begin
         seen_in = SEEN_W'(1);
      end else if (seen_ff < SEEN_W'(WIN_DEPTH)) begin
         seen_in = seen_ff + SEEN_W'(1);
      end else begin
         seen_in = seen_ff;
      end
      pend_in = (seen_in < {1'b0, h}) ? seen_in[HALF_W-1:0] : h;
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.fill       = (seen_ff == '0);
      cmd.hold_shift = (state_ff == S_SHIFT);
      cmd.sum_en     = (state_ff == S_SUM);
      cmd.k          = cnt_ff[K_W-1:0];
      cmd.h          = h;
      cmd.div_load   = (state_ff == S_DIV) && (cnt_ff == '0);
      cmd.div_step   = (state_ff == S_DIV) && (cnt_ff != '0) &&
                       (cnt_ff <= CNT_W'(NUM_WIDTH));
      cmd.finish     = (state_ff == S_DIV) && (cnt_ff == CNT_W'(NUM_WIDTH + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         half_ff  <= HALF_W'(HALF_MAX);
         seen_ff  <= '0;
         last_ff  <= 1'b0;
         step_ff  <= '0;
         pend_ff  <= '0;
         final_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  last_ff <= req_tlast;
                  pend_ff <= pend_in;
                  seen_ff <= req_tlast ? '0 : seen_in;
                  cnt_ff  <= '0;
                  if (seen_in > {1'b0, h}) begin
                     state_ff <= S_SUM;
                     step_ff  <= '0;
                     final_ff <= req_tlast && (h == '0);
                  end else if (req_tlast) begin
                     state_ff <= S_SHIFT;
                     step_ff  <= HALF_W'(1);
                  end
               end
            end
            S_SHIFT: begin
               cnt_ff <= '0;
               if (step_ff > (h - pend_ff)) begin
                  state_ff <= S_SUM;
                  final_ff <= (step_ff == h);
               end else begin
                  step_ff <= step_ff + HALF_W'(1);
               end
            end
            S_SUM: begin
               if (cnt_ff == CNT_W'(WIN_DEPTH - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(NUM_WIDTH + 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (last_ff && (step_ff != h)) begin
                     state_ff <= S_SHIFT;
                     step_ff  <= step_ff + HALF_W'(1);
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_seen_cap: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(WIN_DEPTH))
      else $error("frame count beyond window depth");

   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      step_ff <= HALF_W'(HALF_MAX))
      else $error("flush step beyond half width");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_tready && final_ff) |=> (state_ff == S_IDLE))
      else $error("work continued after the last item of a track");

endmodule

>>> rtl/rdf_datapath.sv
`timescale 1ns / 1ps
module rdf_datapath (
   input  logic                                clock,
   input  rdf_pkg::rdf_cmd_type                cmd,
   input  logic [rdf_pkg::VALUE_WIDTH-1:0]     req_tdata,
   output logic [rdf_pkg::VALUE_WIDTH-1:0]     rsp_tdata
);
   import rdf_pkg::*;

   logic signed [VALUE_WIDTH-1:0] win_ff [WIN_DEPTH];
   logic signed [VALUE_WIDTH-1:0] hold_ff;
   logic signed [NUM_WIDTH-1:0]   acc_ff;
   logic                          neg_ff;
   logic [NUM_WIDTH-1:0]          dq_ff;
   logic [DEN_W-1:0]              rem_ff;
   logic [VALUE_WIDTH-1:0]        out_ff;

   logic signed [K_W:0]           coef;
   logic                          in_band;
   logic signed [NUM_WIDTH-1:0]   prod;
   logic signed [NUM_WIDTH-1:0]   term;
   logic [DEN_W-1:0]              den;
   logic [NUM_WIDTH-1:0]          mag;
   logic [NUM_WIDTH-1:0]          dividend;
   logic [DEN_W:0]                trial;
   logic                          ge;
   logic [VALUE_WIDTH-1:0]        sat;

   // tap k weighs in with (h - k) for k <= 2h
   assign coef    = $signed({2'b00, cmd.h}) - $signed({1'b0, cmd.k});
   assign in_band = (cmd.k <= {cmd.h, 1'b0});
   assign prod    = coef * win_ff[0];
   assign term    = in_band ? prod : '0;

   assign den      = den_of(cmd.h);
   assign mag      = acc_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-acc_ff) : NUM_WIDTH'(acc_ff);
   assign dividend = mag + NUM_WIDTH'(den >> 1);
   assign trial    = {rem_ff, dq_ff[NUM_WIDTH-1]};
   assign ge       = (trial >= {1'b0, den});

   always_comb begin
      if (neg_ff) begin
         if (dq_ff > NUM_WIDTH'(2 ** (VALUE_WIDTH - 1))) begin
            sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         end else begin
            sat = VALUE_WIDTH'(-dq_ff[VALUE_WIDTH-1:0]);
         end
      end else if (dq_ff > NUM_WIDTH'(2 ** (VALUE_WIDTH - 1) - 1)) begin
         sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else begin
         sat = dq_ff[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hold_ff <= req_tdata;
         if (cmd.fill) begin
            for (int i = 0; i < WIN_DEPTH; i++) win_ff[i] <= req_tdata;
         end else begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
            win_ff[0] <= req_tdata;
         end
      end else if (cmd.hold_shift) begin
         for (int i = WIN_DEPTH - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
         win_ff[0] <= hold_ff;
      end else if (cmd.sum_en) begin
         // a full rotation through all WIN_DEPTH taps leaves the window as it was
         for (int i = 0; i < WIN_DEPTH - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[WIN_DEPTH-1] <= win_ff[0];
      end

      if (cmd.sum_en) begin
         acc_ff <= (cmd.k == '0) ? term : acc_ff + term;
      end

      if (cmd.div_load) begin
         neg_ff <= acc_ff[NUM_WIDTH-1];
         dq_ff  <= dividend;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         dq_ff  <= {dq_ff[NUM_WIDTH-2:0], ge};
      end

      if (cmd.finish) begin
         out_ff <= sat;
      end
   end

   assign rsp_tdata = out_ff;

endmodule

>>> rtl/regression_delta_filter.sv
`timescale 1ns / 1ps
// Regression delta filter. Takes one coefficient track, one signed 24-bit frame
// value per item (tlast on the track's last frame) and returns for each frame
// sum_{n=1..h} n*(x[t+n]-x[t-n]) / (2*sum n^2), rounded to nearest (ties away
// from zero) and saturated to 24 bits; frames beyond either end of the track
// repeat the end value. h is the half width register (0..4, above 4 treated as
// 4, 0 gives zero deltas); the user must write it only while the block is idle,
// which the block does not enforce itself. Results lag by h items; the tlast
// item flushes the pending deltas and the last of them carries tlast, after
// which a new track starts. One item at a time: no new item is taken until the
// deltas of the last are out. A delta passes accept, a window scan over 9 taps,
// the serial divider at one quotient bit per cycle, and output, where it waits
// for rsp_tready; a track's last item yields up to h+1 deltas, each after the
// first led by a shift of the end padding.
module regression_delta_filter (
   input  logic        clock,
   input  logic        reset,
   // configuration: half width
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [23:0] sample_value
   input  logic        req_tlast,    // end_of_track
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [23:0] delta_value
   output logic        rsp_tlast     // last_of_track
);
   import rdf_pkg::*;

   rdf_cmd_type cmd;

   // sequencing: window updates, flush shifts, scan, divide, hand-off
   rdf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd)
   );

   // frame window, weighted sum, serial divider, output register
   rdf_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
